// ----- rtl/frac_n_pll_register_generator_macros.svh -----
// ----------------------------------------------------------------------------
// Fractional-N register generator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAC_N_PLL_REGISTER_GENERATOR_MACROS_SVH
`define FRAC_N_PLL_REGISTER_GENERATOR_MACROS_SVH

// same-cycle implication
`define FNPLL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FNPLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fnpll_pkg.sv -----
// ----------------------------------------------------------------------------
// fnpll_pkg
// Types, constants and helpers shared by the register generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fnpll_pkg;

  localparam int WORD_W     = 32;
  localparam int FREQ_W     = 16;
  localparam int IDX_W      = 3;
  localparam int NUM_SHADOW = 6;
  localparam int RCNT_W     = 10;
  localparam int MOD_W      = 12;
  localparam int N_W        = 16;
  localparam int D_W        = 3;
  localparam int FRAC_BITS  = 4;
  localparam int DEXP_MAX   = 6;
  localparam int VCO_WIDE_W = FREQ_W + DEXP_MAX;
  localparam int DIVD_W     = FREQ_W + FRAC_BITS;
  localparam int DIVS_W     = FREQ_W + 1;
  localparam int DIV_STEPS  = DIVD_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [FREQ_W-1:0] REF_FREQ_RST = 16'd1000;

  localparam logic [WORD_W-1:0] MASK_DIV_SEL = 32'h0070_0000;
  localparam logic [WORD_W-1:0] MASK_R0_KEEP = 32'h8000_0007;
  localparam logic [WORD_W-1:0] BIT_EN_MAIN  = 32'h0000_0020;
  localparam logic [WORD_W-1:0] BIT_EN_AUX   = 32'h0000_0100;

  localparam int DSEL_LSB    = 20;
  localparam int RCNT_LSB    = 14;
  localparam int MOD_LSB     = 3;
  localparam int N_LSB       = 15;
  localparam int FRAC_LSB    = 3;
  localparam int DBL_BIT     = 25;
  localparam int HALF_BIT    = 24;
  localparam int EN_MAIN_BIT = 5;
  localparam int EN_AUX_BIT  = 8;

  localparam logic [IDX_W-1:0] REG_W0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_W1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_W2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_W4 = 3'd4;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SETF   = 2'd1,
    ACT_ENABLE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    RK_RAW,
    RK_W4,
    RK_W2,
    RK_W0,
    RK_EN_ITEM,
    RK_EN_MAIN,
    RK_EN_AUX,
    RK_READ,
    RK_ERR
  } res_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ONE,
    ST_ERR,
    ST_DIV_REF,
    ST_CHK_PFD,
    ST_DIV_VCO,
    ST_W4,
    ST_W2,
    ST_W0,
    ST_EN_MAIN,
    ST_EN_AUX
  } fnpll_state_t;

  typedef struct packed {
    logic      load;
    logic      div_start;
    logic      div_vco;
    logic      cap_pfd;
    logic      cap_nf;
    logic      emit;
    res_kind_t kind;
    logic      last;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    rcnt_zero;
    logic    pfd_zero;
    logic    div_done;
    logic    d_same;
    logic    out_free;
  } ctrl_stat_t;

  // output divider exponent from target frequency thresholds
  function automatic logic [D_W-1:0] out_div_exp(input logic [FREQ_W-1:0] f);
    logic [D_W-1:0] d;
    priority if (f < 16'd687)   d = 3'd6;
    else if (f < 16'd1375)      d = 3'd5;
    else if (f < 16'd2750)      d = 3'd4;
    else if (f < 16'd5500)      d = 3'd3;
    else if (f < 16'd11000)     d = 3'd2;
    else if (f < 16'd22000)     d = 3'd1;
    else                        d = 3'd0;
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fnpll_div.sv -----
// ----------------------------------------------------------------------------
// fnpll_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fnpll_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [fnpll_pkg::DIVD_W-1:0] dividend,
  input  wire logic [fnpll_pkg::DIVS_W-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [fnpll_pkg::DIVD_W-1:0]    quotient
);
  import fnpll_pkg::*;

  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[DIVD_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
      cnt_nxt  = STEP_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DIVS_W]) begin
        rem_nxt = diff[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/fnpll_ctrl.sv -----
// ----------------------------------------------------------------------------
// fnpll_ctrl
// Sequencer: item decode, divider phases and result emission order.
// ----------------------------------------------------------------------------
`default_nettype none

module fnpll_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire fnpll_pkg::ctrl_stat_t stat,
  output fnpll_pkg::ctrl_cmd_t       cmd
);
  import fnpll_pkg::*;

  fnpll_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = RK_RAW;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (stat.action)
          ACT_SETF: begin
            if (stat.rcnt_zero) begin
              state_nxt = ST_ERR;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = ST_DIV_REF;
            end
          end
          default: state_nxt = ST_ONE;
        endcase
      end
      ST_ONE: begin
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        unique case (stat.action)
          ACT_WRITE:  cmd.kind = RK_RAW;
          ACT_ENABLE: cmd.kind = RK_EN_ITEM;
          ACT_READ:   cmd.kind = RK_READ;
          default:    cmd.kind = RK_ERR;
        endcase
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_ERR: begin
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        cmd.kind = RK_ERR;
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_DIV_REF: begin
        if (stat.div_done) begin
          cmd.cap_pfd = 1'b1;
          state_nxt   = ST_CHK_PFD;
        end
      end
      ST_CHK_PFD: begin
        if (stat.pfd_zero) begin
          state_nxt = ST_ERR;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_vco   = 1'b1;
          state_nxt     = ST_DIV_VCO;
        end
      end
      ST_DIV_VCO: begin
        if (stat.div_done) begin
          cmd.cap_nf = 1'b1;
          state_nxt  = ST_W4;
        end
      end
      ST_W4: begin
        if (stat.d_same) begin
          state_nxt = ST_W2;
        end else begin
          cmd.emit = 1'b1;
          cmd.kind = RK_W4;
          if (stat.out_free) state_nxt = ST_W2;
        end
      end
      ST_W2: begin
        cmd.emit = 1'b1;
        cmd.kind = RK_W2;
        if (stat.out_free) state_nxt = ST_W0;
      end
      ST_W0: begin
        cmd.emit = 1'b1;
        cmd.kind = RK_W0;
        if (stat.out_free) state_nxt = ST_EN_MAIN;
      end
      ST_EN_MAIN: begin
        cmd.emit = 1'b1;
        cmd.kind = RK_EN_MAIN;
        if (stat.out_free) state_nxt = ST_EN_AUX;
      end
      ST_EN_AUX: begin
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        cmd.kind = RK_EN_AUX;
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/fnpll_dp.sv -----
// ----------------------------------------------------------------------------
// fnpll_dp
// Datapath: shadow words, item capture, divider, word assembly, output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fnpll_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fnpll_pkg::ctrl_cmd_t         cmd,
  output fnpll_pkg::ctrl_stat_t             stat,
  input  wire logic                         cfg_wr_en,
  input  wire logic [fnpll_pkg::FREQ_W-1:0] cfg_wr_data,
  input  wire logic [1:0]                   in_action,
  input  wire logic [fnpll_pkg::WORD_W-1:0] in_word,
  input  wire logic [fnpll_pkg::IDX_W-1:0]  in_reg_index,
  input  wire logic [fnpll_pkg::FREQ_W-1:0] in_target_freq,
  input  wire logic                         in_out_select,
  input  wire logic                         in_out_enable,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_tx_valid,
  output logic [fnpll_pkg::WORD_W-1:0]      out_tx_word,
  output logic [fnpll_pkg::WORD_W-1:0]      out_read_data,
  output logic                              out_error,
  output logic                              out_last
);
  import fnpll_pkg::*;
  `include "frac_n_pll_register_generator_macros.svh"

  logic [FREQ_W-1:0] ref_freq_r;
  logic [WORD_W-1:0] shadow_r [NUM_SHADOW];

  action_t           act_r;
  logic [WORD_W-1:0] word_r;
  logic [IDX_W-1:0]  idx_r;
  logic [FREQ_W-1:0] tf_r;
  logic              sel_r;
  logic              en_r;
  logic [D_W-1:0]    d_r;
  logic [WORD_W-1:0] r4_r, r2_r, r1_r, r0_r;
  logic [DIVS_W-1:0] pfd_r;
  logic [N_W-1:0]    n_r;
  logic [MOD_W-1:0]  frac_r;

  logic              out_valid_r;
  logic              out_tx_valid_r;
  logic [WORD_W-1:0] out_tx_word_r;
  logic [WORD_W-1:0] out_read_data_r;
  logic              out_error_r;
  logic              out_last_r;

  logic [RCNT_W-1:0]     rcnt;
  logic [MOD_W-1:0]      mod_val;
  logic [D_W-1:0]        cur_d;
  logic [VCO_WIDE_W-1:0] vco_wide;
  logic [FREQ_W-1:0]     vco;
  logic [DIVD_W-1:0]     div_dividend;
  logic [DIVS_W-1:0]     div_divisor;
  logic [DIVD_W-1:0]     div_q;
  logic                  div_busy;
  logic                  div_done;
  logic [DIVS_W-1:0]     pfd_cap;
  logic [2*N_W-1:0]      prod_wide;
  logic [N_W-1:0]        prod;
  logic [WORD_W-1:0]     shadow4;
  logic                  res_tx_valid;
  logic [WORD_W-1:0]     res_word;
  logic [WORD_W-1:0]     res_read;
  logic                  res_error;
  logic                  out_free;
  logic                  fire;

  assign rcnt     = r2_r[RCNT_LSB +: RCNT_W];
  assign mod_val  = r1_r[MOD_LSB +: MOD_W];
  assign cur_d    = r4_r[DSEL_LSB +: D_W];
  assign vco_wide = {{(VCO_WIDE_W-FREQ_W){1'b0}}, tf_r} << d_r;
  assign vco      = vco_wide[FREQ_W-1:0];

  assign div_dividend = cmd.div_vco ? {vco, {FRAC_BITS{1'b0}}}
                                    : {{(DIVD_W-FREQ_W){1'b0}}, ref_freq_r};
  assign div_divisor  = cmd.div_vco ? pfd_r : {{(DIVS_W-RCNT_W){1'b0}}, rcnt};

  fnpll_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign pfd_cap   = ({1'b0, div_q[FREQ_W-1:0]} << r2_r[DBL_BIT]) >> r2_r[HALF_BIT];
  assign prod_wide = {{(2*N_W-FRAC_BITS){1'b0}}, div_q[FRAC_BITS-1:0]}
                   * {{(2*N_W-MOD_W){1'b0}}, mod_val};
  assign prod      = prod_wide[N_W-1:0];

  assign shadow4 = shadow_r[REG_W4];

  always_comb begin
    res_tx_valid = 1'b0;
    res_word     = '0;
    res_read     = '0;
    res_error    = 1'b0;
    unique case (cmd.kind)
      RK_RAW: begin
        res_tx_valid = 1'b1;
        res_word     = word_r;
      end
      RK_W4: begin
        res_tx_valid = 1'b1;
        res_word     = (r4_r & ~MASK_DIV_SEL) | (WORD_W'(d_r) << DSEL_LSB);
      end
      RK_W2: begin
        res_tx_valid = 1'b1;
        res_word     = r2_r;
      end
      RK_W0: begin
        res_tx_valid = 1'b1;
        res_word     = (r0_r & MASK_R0_KEEP) | (WORD_W'(n_r) << N_LSB)
                     | (WORD_W'(frac_r) << FRAC_LSB);
      end
      RK_EN_ITEM: begin
        res_tx_valid = 1'b1;
        res_word     = sel_r ? ((shadow4 & ~BIT_EN_AUX) | (WORD_W'(en_r) << EN_AUX_BIT))
                             : ((shadow4 & ~BIT_EN_MAIN) | (WORD_W'(en_r) << EN_MAIN_BIT));
      end
      RK_EN_MAIN: begin
        res_tx_valid = 1'b1;
        res_word     = shadow4 | BIT_EN_MAIN;
      end
      RK_EN_AUX: begin
        res_tx_valid = 1'b1;
        res_word     = shadow4 | BIT_EN_AUX;
      end
      RK_READ: begin
        res_read = (idx_r < IDX_W'(NUM_SHADOW)) ? shadow_r[idx_r] : '1;
      end
      RK_ERR: begin
        res_error = 1'b1;
      end
      default: begin
        res_error = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = cmd.emit && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_freq_r  <= REF_FREQ_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SHADOW; i++) begin
        shadow_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) ref_freq_r <= cfg_wr_data;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (fire && res_tx_valid && (res_word[IDX_W-1:0] < IDX_W'(NUM_SHADOW))) begin
        shadow_r[res_word[IDX_W-1:0]] <= res_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action_t'(in_action);
      word_r <= in_word;
      idx_r  <= in_reg_index;
      tf_r   <= in_target_freq;
      sel_r  <= in_out_select;
      en_r   <= in_out_enable;
      d_r    <= out_div_exp(in_target_freq);
      r4_r   <= shadow_r[REG_W4];
      r2_r   <= shadow_r[REG_W2];
      r1_r   <= shadow_r[REG_W1];
      r0_r   <= shadow_r[REG_W0];
    end
    if (cmd.cap_pfd) pfd_r <= pfd_cap;
    if (cmd.cap_nf) begin
      n_r    <= div_q[DIVD_W-1:FRAC_BITS];
      frac_r <= prod[N_W-1:FRAC_BITS];
    end
    if (fire) begin
      out_tx_valid_r  <= res_tx_valid;
      out_tx_word_r   <= res_word;
      out_read_data_r <= res_read;
      out_error_r     <= res_error;
      out_last_r      <= cmd.last;
    end
  end

  assign stat.action    = act_r;
  assign stat.rcnt_zero = (rcnt == '0);
  assign stat.pfd_zero  = (pfd_r == '0);
  assign stat.div_done  = div_done;
  assign stat.d_same    = (cur_d == d_r);
  assign stat.out_free  = out_free;

  assign out_valid     = out_valid_r;
  assign out_tx_valid  = out_tx_valid_r;
  assign out_tx_word   = out_tx_word_r;
  assign out_read_data = out_read_data_r;
  assign out_error     = out_error_r;
  assign out_last      = out_last_r;

  `FNPLL_ASSERT_SAME(a_div_start_idle, cmd.div_start, !div_busy,
                     "divider started while busy")
  `FNPLL_ASSERT_SAME(a_nf_pfd_nonzero, cmd.cap_nf, pfd_r != '0,
                     "N and FRAC captured with zero comparison frequency")
  `FNPLL_ASSERT_SAME(a_err_beat, out_valid_r && out_error_r,
                     !out_tx_valid_r && out_last_r && out_tx_word_r == '0,
                     "error beat carries a word or is not last")
  `FNPLL_ASSERT_NEXT(a_shadow4_update,
                     fire && res_tx_valid && res_word[IDX_W-1:0] == REG_W4,
                     shadow_r[REG_W4] == $past(res_word),
                     "shadow word 4 not updated by sent word")

endmodule

`default_nettype wire

// ----- rtl/frac_n_pll_register_generator.sv -----
// ----------------------------------------------------------------------------
// frac_n_pll_register_generator
// Control-word generator for a fractional-N synthesizer with shadow copy.
// ----------------------------------------------------------------------------
// Input channel (in_*): one beat per command (raw write, set frequency,
// output enable, shadow read). in_stall is high while a command is in work;
// one command is handled at a time.
// Result channel (out_*): one to five beats per command, out_last on the
// final one. An output register decouples the sides, so the next command
// is taken while the last beat still waits to be taken.
// A raw write, enable or read passes the decode state and the single-beat
// state before its beat is registered at the output.
// Set frequency runs two divisions on the shared restoring divider
// (reference / R, then target shifted by the output divider exponent over
// the comparison frequency, with 4 fraction bits) before its first beat.
// out_stall holds the output beat and pauses the sequencer; nothing is lost.
// cfg_wr_en writes the reference frequency; reset sets it to 100 MHz and
// clears the six shadow words and all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module frac_n_pll_register_generator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [fnpll_pkg::FREQ_W-1:0] cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   in_action,
  input  wire logic [fnpll_pkg::WORD_W-1:0] in_word,
  input  wire logic [fnpll_pkg::IDX_W-1:0]  in_reg_index,
  input  wire logic [fnpll_pkg::FREQ_W-1:0] in_target_freq,
  input  wire logic                         in_out_select,
  input  wire logic                         in_out_enable,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_tx_valid,
  output logic [fnpll_pkg::WORD_W-1:0]      out_tx_word,
  output logic [fnpll_pkg::WORD_W-1:0]      out_read_data,
  output logic                              out_error,
  output logic                              out_last
);
  import fnpll_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  fnpll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fnpll_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_action      (in_action),
    .in_word        (in_word),
    .in_reg_index   (in_reg_index),
    .in_target_freq (in_target_freq),
    .in_out_select  (in_out_select),
    .in_out_enable  (in_out_enable),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_valid   (out_tx_valid),
    .out_tx_word    (out_tx_word),
    .out_read_data  (out_read_data),
    .out_error      (out_error),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// ----- tb/tb_frac_n_pll_register_generator.sv -----
// ----------------------------------------------------------------------------
// tb_frac_n_pll_register_generator
// Self-checking bench for the synthesizer control-word generator. A clocked
// driver sends queued commands in random bursts, a clocked monitor stalls the
// result channel on its own pattern and checks every beat against a local
// shadow-register predictor. The reference frequency is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frac_n_pll_register_generator;
  import fnpll_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [2:0]  IDX_W3      = 3'd3;
  localparam logic [2:0]  IDX_W5      = 3'd5;
  localparam logic [2:0]  IDX_INV6    = 3'd6;
  localparam logic [2:0]  IDX_INV7    = 3'd7;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

  typedef struct packed {
    action_t     action;
    logic [31:0] word;
    logic [2:0]  reg_index;
    logic [15:0] target_freq;
    logic        out_select;
    logic        out_enable;
  } pll_cmd_t;

  typedef struct packed {
    logic        tx_valid;
    logic [31:0] tx_word;
    logic [31:0] read_data;
    logic        error;
    logic        last;
  } pll_beat_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        cfg_wr_en      = 1'b0;
  logic [15:0] cfg_wr_data    = '0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action      = '0;
  logic [31:0] in_word        = '0;
  logic [2:0]  in_reg_index   = '0;
  logic [15:0] in_target_freq = '0;
  logic        in_out_select  = 1'b0;
  logic        in_out_enable  = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        out_tx_valid;
  logic [31:0] out_tx_word;
  logic [31:0] out_read_data;
  logic        out_error;
  logic        out_last;

  pll_cmd_t    cmd_q[$];
  pll_cmd_t    cur_cmd;
  pll_beat_t   word_beats_q[$];
  pll_beat_t   new_beats[$];
  logic [31:0] shadow_model[NUM_SHADOW];
  logic [15:0] ref_model;
  int          queued_cnt   = 0;
  int          accepted_cnt = 0;
  int          err_cnt      = 0;
  int          cycle_cnt    = 0;

  frac_n_pll_register_generator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_word        (in_word),
    .in_reg_index   (in_reg_index),
    .in_target_freq (in_target_freq),
    .in_out_select  (in_out_select),
    .in_out_enable  (in_out_enable),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_valid   (out_tx_valid),
    .out_tx_word    (out_tx_word),
    .out_read_data  (out_read_data),
    .out_error      (out_error),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------- predictor ----------------

  function automatic void send_word(input logic [31:0] w);
    if (w[2:0] < NUM_SHADOW) shadow_model[w[2:0]] = w;
    new_beats.push_back('{1'b1, w, 32'd0, 1'b0, 1'b0});
  endfunction

  function automatic void apply_enable(input logic sel, input logic en);
    logic [31:0] w;
    w = shadow_model[REG_W4];
    if (sel) w[EN_AUX_BIT] = en;
    else w[EN_MAIN_BIT] = en;
    send_word(w);
  endfunction

  function automatic void tune_to(input logic [15:0] f);
    logic [31:0] r4, r2, r1, r0, pfd, vco, n, res, frac, w;
    logic [9:0]  rcnt;
    logic [11:0] modv;
    logic [2:0]  d;
    r4   = shadow_model[REG_W4];
    r2   = shadow_model[REG_W2];
    r1   = shadow_model[REG_W1];
    r0   = shadow_model[REG_W0];
    rcnt = r2[23:14];
    modv = r1[14:3];
    pfd  = '0;
    if (rcnt != 0) begin
      pfd = {16'd0, ref_model} / {22'd0, rcnt};
      pfd = (pfd << r2[DBL_BIT]) >> r2[HALF_BIT];
    end
    if (pfd == 0) begin
      new_beats.push_back('{1'b0, 32'd0, 32'd0, 1'b1, 1'b0});
      return;
    end
    if (f < 16'd687) d = 3'd6;
    else if (f < 16'd1375) d = 3'd5;
    else if (f < 16'd2750) d = 3'd4;
    else if (f < 16'd5500) d = 3'd3;
    else if (f < 16'd11000) d = 3'd2;
    else if (f < 16'd22000) d = 3'd1;
    else d = 3'd0;
    vco  = {16'd0, f} << d;
    n    = vco / pfd;
    res  = ((vco % pfd) << 4) / pfd;
    frac = (res * {20'd0, modv}) >> 4;
    if (d != r4[22:20]) begin
      w = r4;
      w[22:20] = d;
      send_word(w);
    end
    send_word(r2);
    w = r0 & MASK_R0_KEEP;
    w[30:15] = n[15:0];
    w[14:3]  = frac[11:0];
    send_word(w);
    apply_enable(1'b0, 1'b1);
    apply_enable(1'b1, 1'b1);
  endfunction

  function automatic void predict_pll_words(input pll_cmd_t c);
    pll_beat_t b;
    new_beats.delete();
    case (c.action)
      ACT_WRITE:  send_word(c.word);
      ACT_SETF:   tune_to(c.target_freq);
      ACT_ENABLE: apply_enable(c.out_select, c.out_enable);
      default: begin
        new_beats.push_back('{1'b0, 32'd0,
          (c.reg_index < NUM_SHADOW) ? shadow_model[c.reg_index] : ALL_ONES, 1'b0, 1'b0});
      end
    endcase
    foreach (new_beats[i]) begin
      b = new_beats[i];
      b.last = (i == new_beats.size() - 1);
      word_beats_q.push_back(b);
    end
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic pll_cmd_t mk_cmd(input action_t a, input logic [31:0] w,
                                      input logic [2:0] idx, input logic [15:0] f,
                                      input logic sel, input logic en);
    pll_cmd_t c;
    c.action      = a;
    c.word        = (a == ACT_WRITE) ? w : $urandom();
    c.reg_index   = (a == ACT_READ) ? idx : 3'($urandom());
    c.target_freq = (a == ACT_SETF) ? f : 16'($urandom());
    c.out_select  = (a == ACT_ENABLE) ? sel : 1'($urandom());
    c.out_enable  = (a == ACT_ENABLE) ? en : 1'($urandom());
    return c;
  endfunction

  function automatic void push_cmd(input pll_cmd_t c);
    cmd_q.push_back(c);
    queued_cnt++;
  endfunction

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || word_beats_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_ref(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ref_model = v;
  endtask

  // mostly tuning sequences (MOD word, R word, optional divider word, retunes),
  // the rest stray enables, reads, raw words and random commands
  task automatic gen_traffic(input int n_items);
    int          stop_at, pick, reps;
    logic [31:0] w;
    logic [9:0]  r;
    logic [15:0] f;
    int          thr[6];
    thr = '{687, 1375, 2750, 5500, 11000, 22000};
    stop_at = queued_cnt + n_items;
    while (queued_cnt < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        w = $urandom();
        w[2:0] = REG_W1;
        push_cmd(mk_cmd(ACT_WRITE, w, '0, '0, 1'b0, 1'b0));
        case ($urandom_range(0, 19))
          0:                 r = '0;
          1, 2, 3:           r = 10'($urandom());
          4, 5, 6, 7, 8, 9:  r = 10'($urandom_range(1, 64));
          default:           r = 10'($urandom_range(1, 4));
        endcase
        w = $urandom();
        w[2:0]   = REG_W2;
        w[23:14] = r;
        push_cmd(mk_cmd(ACT_WRITE, w, '0, '0, 1'b0, 1'b0));
        if ($urandom_range(0, 1)) begin
          w = $urandom();
          w[2:0] = REG_W4;
          push_cmd(mk_cmd(ACT_WRITE, w, '0, '0, 1'b0, 1'b0));
        end
        reps = $urandom_range(1, 3);
        repeat (reps) begin
          case ($urandom_range(0, 3))
            0:       f = 16'($urandom());
            1:       f = 16'(thr[$urandom_range(0, 5)] + $urandom_range(0, 4) - 2);
            2:       f = 16'($urandom_range(0, 700));
            default: f = 16'($urandom_range(0, 30000));
          endcase
          push_cmd(mk_cmd(ACT_SETF, '0, '0, f, 1'b0, 1'b0));
        end
        if ($urandom_range(0, 2) == 0)
          push_cmd(mk_cmd(ACT_ENABLE, '0, '0, '0, 1'($urandom()), 1'($urandom())));
        if ($urandom_range(0, 2) == 0)
          push_cmd(mk_cmd(ACT_READ, '0, 3'($urandom()), '0, 1'b0, 1'b0));
      end else if (pick == 6) begin
        push_cmd(mk_cmd(ACT_ENABLE, '0, '0, '0, 1'($urandom()), 1'($urandom())));
      end else if (pick == 7) begin
        push_cmd(mk_cmd(ACT_READ, '0, 3'($urandom()), '0, 1'b0, 1'b0));
      end else if (pick == 8) begin
        push_cmd(mk_cmd(ACT_WRITE, $urandom(), '0, '0, 1'b0, 1'b0));
      end else begin
        push_cmd(mk_cmd(action_t'($urandom_range(0, 3)), $urandom(), 3'($urandom()),
                        16'($urandom()), 1'($urandom()), 1'($urandom())));
      end
    end
  endtask

  // ---------------- main sequence ----------------

  initial begin
    foreach (shadow_model[i]) shadow_model[i] = '0;
    ref_model = REF_FREQ_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // shadow empty: R is zero, enable lands in word 0
    push_cmd(mk_cmd(ACT_READ, '0, REG_W0, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_READ, '0, IDX_INV7, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_SETF, '0, '0, 16'd1000, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_ENABLE, '0, '0, '0, 1'b0, 1'b1));
    push_cmd(mk_cmd(ACT_WRITE, 32'h0000_7FF9, '0, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_WRITE, 32'h0000_4002, '0, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_WRITE, 32'h0000_0004, '0, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_WRITE, 32'h8000_0000, '0, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_WRITE, 32'hFFFF_FFFE, '0, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_WRITE, ALL_ONES, '0, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_SETF, '0, '0, 16'd0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_SETF, '0, '0, 16'd687, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_SETF, '0, '0, 16'd2750, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_SETF, '0, '0, 16'd5500, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_SETF, '0, '0, 16'd11000, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_SETF, '0, '0, 16'd22000, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_SETF, '0, '0, 16'd65535, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_SETF, '0, '0, 16'd65535, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_ENABLE, '0, '0, '0, 1'b1, 1'b0));
    push_cmd(mk_cmd(ACT_ENABLE, '0, '0, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_ENABLE, '0, '0, '0, 1'b1, 1'b1));
    // R above reference: comparison frequency rounds to zero
    push_cmd(mk_cmd(ACT_WRITE, 32'h03FF_C002, '0, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_SETF, '0, '0, 16'd5000, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_READ, '0, REG_W2, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_READ, '0, IDX_INV6, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_READ, '0, IDX_W5, '0, 1'b0, 1'b0));
    push_cmd(mk_cmd(ACT_READ, '0, IDX_W3, '0, 1'b0, 1'b0));
    wait_idle();

    write_ref(16'd65535);
    gen_traffic(30);
    wait_idle();
    write_ref(16'd1);
    gen_traffic(20);
    wait_idle();
    write_ref(16'($urandom_range(2, 65534)));
    gen_traffic(35);
    wait_idle();
    write_ref(16'd400);
    gen_traffic(20);
    wait_idle();
    write_ref(REF_FREQ_RST);
    gen_traffic(20);
    wait_idle();

    repeat (80) @(posedge clk);
    foreach (word_beats_q[i])
      report_mismatch($sformatf("beat still expected: tx_word %h", word_beats_q[i].tx_word));
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------- driver ----------------

  always @(posedge clk) begin : drv
    logic taken;
    int   burst_left;
    int   gap_left;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        predict_pll_words(cur_cmd);
        accepted_cnt++;
      end
      if (!in_valid || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          in_valid       <= 1'b1;
          in_action      <= cur_cmd.action;
          in_word        <= cur_cmd.word;
          in_reg_index   <= cur_cmd.reg_index;
          in_target_freq <= cur_cmd.target_freq;
          in_out_select  <= cur_cmd.out_select;
          in_out_enable  <= cur_cmd.out_enable;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 10);
            gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 4);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin : mon
    pll_beat_t exp_b;
    logic      nxt_stall;
    int        stall_mode;
    int        mode_left;
    int        stall_run;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode = 0;
      mode_left  = 0;
      stall_run  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (word_beats_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: tx_word %h", out_tx_word));
        end else begin
          exp_b = word_beats_q.pop_front();
          if (out_tx_valid !== exp_b.tx_valid)
            report_mismatch($sformatf("tx_valid %b, want %b", out_tx_valid, exp_b.tx_valid));
          if (out_tx_word !== exp_b.tx_word)
            report_mismatch($sformatf("tx_word %h, want %h", out_tx_word, exp_b.tx_word));
          if (out_read_data !== exp_b.read_data)
            report_mismatch($sformatf("read_data %h, want %h", out_read_data,
                                      exp_b.read_data));
          if (out_error !== exp_b.error)
            report_mismatch($sformatf("error %b, want %b", out_error, exp_b.error));
          if (out_last !== exp_b.last)
            report_mismatch($sformatf("last %b, want %b", out_last, exp_b.last));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: nxt_stall = 1'b0;
        1: nxt_stall = ($urandom_range(0, 2) == 0);
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            nxt_stall = 1'b1;
          end else begin
            nxt_stall = 1'b0;
            if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(3, 15);
          end
        end
      endcase
      out_stall <= nxt_stall;
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/fnpll_pkg.sv
rtl/fnpll_div.sv
rtl/fnpll_ctrl.sv
rtl/fnpll_dp.sv
rtl/frac_n_pll_register_generator.sv
tb/tb_frac_n_pll_register_generator.sv
